// File: rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Both expect clk and rst to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define SAPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition at one edge implies a condition at the next edge.
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sapq_pkg.sv
package sapq_pkg;

  // Queue geometry
  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } sapq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;
  } sapq_rsp_t;

endpackage

// File: rtl/sorted_array_priority_queue.sv
// Min-priority queue of up to CAPACITY signed 32-bit values, held in ascending
// order in a ring inside one synchronous memory with one read and one write
// port. An insert into a non-empty queue reads the last entry, then moves each
// larger entry up a place, each move needing one memory read followed by a
// compare, and then writes the new value into the freed place. A delete reads
// the front entry and returns it, and a display streams the held entries from
// the front, one entry per cycle while the output is not stalled. Full and
// empty replies are issued from the response state. The block handles one
// item at a time: req_stall is high from acceptance until the last result of
// that item has entered the output register. A result may wait in the output
// register while the next item is accepted. Unused command codes are dropped
// with no result. No clearing pass runs after reset.
module sorted_array_priority_queue import sapq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  sapq_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output sapq_rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_OUT,
    S_DISP,
    S_RESP
  } state_t;

  localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t                   state;
  logic [IDX_W-1:0]         front;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         jdx;
  logic signed [DATA_W-1:0] val;
  logic [1:0]               resp_status;

  logic [DATA_W-1:0]        mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata;
  logic                     re;
  logic                     we;
  logic [IDX_W-1:0]         raddr;
  logic [IDX_W-1:0]         waddr;
  logic [DATA_W-1:0]        wdata;

  logic accept;
  logic out_free;
  logic rsp_load;
  logic less;
  logic disp_last;
  logic [IDX_W-1:0] slot_cnt_m1;
  logic [IDX_W-1:0] slot_j;
  logic [IDX_W-1:0] slot_jm2;
  logic [IDX_W-1:0] slot_1;
  logic [IDX_W-1:0] slot_i1;

  // Ring position of an offset from the front
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [IDX_W-1:0] o);
    logic [IDX_W:0] s;
    s = {1'b0, f} + {1'b0, o};
    if (s >= CAP_EXT) s = s - CAP_EXT;
    return s[IDX_W-1:0];
  endfunction

  // Handshake and decode
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = out_free && (state == S_INS_PUT || state == S_DEL_OUT ||
                                  state == S_DISP || state == S_RESP);
  assign less      = (val < rdata);
  assign disp_last = ((CNT_W'(jdx) + CNT_W'(1)) == count);

  assign slot_cnt_m1 = slot_of(front, IDX_W'(count - CNT_W'(1)));
  assign slot_j      = slot_of(front, jdx);
  assign slot_jm2    = slot_of(front, jdx - IDX_W'(2));
  assign slot_1      = slot_of(front, IDX_W'(1));
  assign slot_i1     = slot_of(front, jdx + IDX_W'(1));

  // Drive the memory ports
  always_comb begin
    re    = 1'b0;
    raddr = front;
    we    = 1'b0;
    waddr = slot_j;
    wdata = val;
    unique case (state)
      S_IDLE: begin
        if (accept && count != '0) begin
          if (req.command == CMD_INSERT && count < CAP_CNT) begin
            re    = 1'b1;
            raddr = slot_cnt_m1;
          end else if (req.command == CMD_DELETE || req.command == CMD_DISPLAY) begin
            re    = 1'b1;
            raddr = front;
          end
        end
      end
      S_INS_CMP: begin
        if (less) begin
          we    = 1'b1;
          wdata = rdata;
          if (jdx > IDX_W'(1)) begin
            re    = 1'b1;
            raddr = slot_jm2;
          end
        end
      end
      S_INS_PUT: begin
        we = out_free;
      end
      S_DISP: begin
        if (out_free && !disp_last) begin
          re    = 1'b1;
          raddr = slot_i1;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Sequence commands and hold the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val <= req.value;
            case (req.command)
              CMD_INSERT: begin
                if (count >= CAP_CNT) begin
                  resp_status <= ST_FULL;
                  state       <= S_RESP;
                end else if (count == '0) begin
                  jdx   <= '0;
                  state <= S_INS_PUT;
                end else begin
                  jdx   <= IDX_W'(count);
                  state <= S_INS_CMP;
                end
              end
              CMD_DELETE: begin
                if (count == '0) begin
                  front       <= '0;
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  state <= S_DEL_OUT;
                end
              end
              CMD_DISPLAY: begin
                jdx <= '0;
                if (count == '0) begin
                  resp_status <= ST_EMPTY;
                  state       <= S_RESP;
                end else begin
                  state <= S_DISP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // Move one larger entry up a place per cycle
        S_INS_CMP: begin
          if (less) begin
            jdx <= jdx - IDX_W'(1);
            if (jdx == IDX_W'(1)) state <= S_INS_PUT;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          if (out_free) begin
            rsp.status    <= ST_OK;
            rsp.value_res <= '0;
            rsp.last      <= 1'b1;
            count         <= count + CNT_W'(1);
            state         <= S_IDLE;
          end
        end
        S_DEL_OUT: begin
          if (out_free) begin
            rsp.status    <= ST_OK;
            rsp.value_res <= rdata;
            rsp.last      <= 1'b1;
            front         <= slot_1;
            count         <= count - CNT_W'(1);
            state         <= S_IDLE;
          end
        end
        // Stream entries from the front
        S_DISP: begin
          if (out_free) begin
            rsp.status    <= ST_OK;
            rsp.value_res <= rdata;
            rsp.last      <= disp_last;
            if (disp_last) state <= S_IDLE;
            else jdx <= jdx + IDX_W'(1);
          end
        end
        S_RESP: begin
          if (out_free) begin
            rsp.status    <= resp_status;
            rsp.value_res <= '0;
            rsp.last      <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sapq_checker.sv
`include "assert_macros.svh"

module sapq_checker import sapq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input sapq_req_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input sapq_rsp_t rsp
);

  // A stalled result holds
  `SAPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

  // Full and empty replies are single, last and carry zero
  `SAPQ_ASSERT(a_err_shape, !(rsp_valid && rsp.status != ST_OK) || (rsp.last && rsp.value_res == '0), "error reply malformed")

  // A valid command keeps the block busy at the next edge
  `SAPQ_ASSERT_NEXT(a_busy_after, req_valid && !req_stall && (req.command == CMD_INSERT || req.command == CMD_DELETE || req.command == CMD_DISPLAY), req_stall, "item accepted on back-to-back edges")

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (.*);
